// ===== sv/fcd_pkg.sv =====
// Package for the frame change detector: field widths, FNV-1a constants,
// item kind codes and the byte fold function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

    localparam int BYTE_W = 8;
    localparam int HASH_W = 32;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [0:0] {
        FUNC_DATA       = 1'b0,
        FUNC_INVALIDATE = 1'b1
    } t_func;

    // xor the byte in, then multiply by 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
    function automatic logic [HASH_W-1:0] fcd_fold(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
    endfunction

endpackage

`default_nettype wire

// ===== sv/frame_change_detector_fnv1a.sv =====
// Frame change detector: running FNV-1a 32-bit hash over frame bytes with a
// send decision per frame. Depends on fcd_pkg.
//
// Takes one item per clock cycle, unless a frame's result is held up by a full
// result register that is not taken. An item is held in an input register;
// from there the byte is folded into the running hash (xor, then multiply by
// the FNV prime as a sum of shifts) and, on the byte marked by tlast, the send
// decision is written to the result register. The rate is set by the running
// hash loop, one fold per cycle. Input tuser set marks an invalidate item,
// which forces the next frame to be sent and gives no result. Output tuser is
// the send flag, tdata the frame hash. The input register also serves as a
// skid stage while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module frame_change_detector_fnv1a (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [fcd_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic                        s_axis_tlast,  // frame_end
    input  wire logic                        s_axis_tuser,  // [0] func
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [fcd_pkg::HASH_W-1:0]       m_axis_tdata,  // [31:0] frame_hash
    output logic                             m_axis_tuser   // [0] send_frame
);
    import fcd_pkg::*;

    logic              r_in_valid;
    t_func             r_in_func;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] r_sent_hash;
    logic              r_sent_valid;
    logic              r_forced;

    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_hash;
    logic              r_out_send;

    logic [HASH_W-1:0] n_hash;
    logic [HASH_W-1:0] n_sent_hash;
    logic              n_sent_valid;
    logic              n_forced;
    logic              n_out_valid;

    logic [HASH_W-1:0] w_fold;
    logic              w_result;
    logic              w_advance;
    logic              w_send;

    assign w_fold    = fcd_fold(r_hash, r_in_byte);
    assign w_result  = r_in_valid && (r_in_func == FUNC_DATA) && r_in_last;
    assign w_advance = r_in_valid && (!w_result || !r_out_valid || m_axis_tready);
    assign w_send    = r_forced || !r_sent_valid || (w_fold != r_sent_hash);

    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_hash;
    assign m_axis_tuser  = r_out_send;

    always_comb begin
        n_hash       = r_hash;
        n_sent_hash  = r_sent_hash;
        n_sent_valid = r_sent_valid;
        n_forced     = r_forced;
        n_out_valid  = r_out_valid && !m_axis_tready;
        if (w_advance) begin
            case (r_in_func)
                FUNC_INVALIDATE: begin
                    n_sent_valid = 1'b0;
                    n_forced     = 1'b1;
                end
                default: begin
                    if (r_in_last) begin
                        n_hash      = FNV_BASIS;
                        n_out_valid = 1'b1;
                        if (w_send) begin
                            n_sent_hash  = w_fold;
                            n_sent_valid = 1'b1;
                            n_forced     = 1'b0;
                        end
                    end else begin
                        n_hash = w_fold;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_hash       <= FNV_BASIS;
            r_sent_hash  <= '0;
            r_sent_valid <= 1'b0;
            r_forced     <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_valid   <= (s_axis_tvalid && s_axis_tready) || (r_in_valid && !w_advance);
            r_hash       <= n_hash;
            r_sent_hash  <= n_sent_hash;
            r_sent_valid <= n_sent_valid;
            r_forced     <= n_forced;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= t_func'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_advance && w_result) begin
            r_out_hash <= w_fold;
            r_out_send <= w_send;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fcd_checker.sv =====
// Port-level checks for the frame change detector and the bind that attaches
// them. Depends on frame_change_detector_fnv1a and fcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic                        s_axis_tlast,
    input wire logic                        s_axis_tuser,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [fcd_pkg::HASH_W-1:0]  m_axis_tdata,
    input wire logic                        m_axis_tuser
);
    import fcd_pkg::*;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast
                                       && (s_axis_tuser == FUNC_DATA), 2))
        else $error("result without an accepted last data item");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused while no result is pending");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result shown straight after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid && !m_axis_tready)
        |-> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind frame_change_detector_fnv1a fcd_checker u_fcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for frame_change_detector_fnv1a: streams frame bytes and invalidate
// items, predicts each send verdict and FNV-1a hash, and checks every result.
// Depends on fcd_pkg and the frame_change_detector_fnv1a top level.
`timescale 1ns / 1ps

module testbench;
    import fcd_pkg::*;

    typedef struct packed {
        logic                send_frame;
        logic [HASH_W-1:0]   frame_hash;
    } t_frame_verdict;

    typedef struct packed {
        t_func               func;
        logic [BYTE_W-1:0]   data_byte;
        logic                frame_end;
    } t_bus_item;

    class t_frame_verdict_board;
        logic [HASH_W-1:0] hash_acc;
        logic [HASH_W-1:0] last_sent_hash;
        bit                last_sent_valid;
        bit                refresh_pending;
        t_frame_verdict    awaited_verdicts[$];
        int                errors;

        function new();
            hash_acc        = FNV_BASIS;
            last_sent_hash  = '0;
            last_sent_valid = 1'b0;
            refresh_pending = 1'b1;
            errors          = 0;
        endfunction

        function void take_item(t_func func, logic [BYTE_W-1:0] data_byte, logic frame_end);
            logic [HASH_W-1:0] folded;
            t_frame_verdict    verdict;
            if (func == FUNC_INVALIDATE) begin
                last_sent_valid = 1'b0;
                refresh_pending = 1'b1;
                return;
            end
            folded = (hash_acc ^ {{(HASH_W-BYTE_W){1'b0}}, data_byte}) * FNV_PRIME;
            if (!frame_end) begin
                hash_acc = folded;
                return;
            end
            verdict.send_frame = refresh_pending || !last_sent_valid
                                 || (folded != last_sent_hash);
            verdict.frame_hash = folded;
            awaited_verdicts.push_back(verdict);
            if (verdict.send_frame) begin
                last_sent_hash  = folded;
                last_sent_valid = 1'b1;
                refresh_pending = 1'b0;
            end
            hash_acc = FNV_BASIS;
        endfunction

        function void match_verdict(logic send_frame, logic [HASH_W-1:0] frame_hash);
            t_frame_verdict want;
            if (awaited_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result send=%0b hash=%08h",
                         $time, send_frame, frame_hash);
                return;
            end
            want = awaited_verdicts.pop_front();
            if (send_frame !== want.send_frame) begin
                errors++;
                $display("%0t: send_frame expected %0b actual %0b",
                         $time, want.send_frame, send_frame);
            end
            if (frame_hash !== want.frame_hash) begin
                errors++;
                $display("%0t: frame_hash expected %08h actual %08h",
                         $time, want.frame_hash, frame_hash);
            end
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                s_axis_tvalid  = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata   = '0;  // [7:0] data_byte
    logic                s_axis_tlast   = 1'b0;  // frame_end
    logic                s_axis_tuser   = 1'b0;  // [0] func
    logic                m_axis_tvalid;
    logic                m_axis_tready  = 1'b0;
    logic [HASH_W-1:0]   m_axis_tdata;  // [31:0] frame_hash
    logic                m_axis_tuser;  // [0] send_frame

    t_frame_verdict_board board = new();
    t_bus_item           stim_q[$];
    t_bus_item           tx_item;
    logic [BYTE_W-1:0]   prev_frame[$];
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    bit                  pressure_go = 1'b0;
    logic                rx_hold     = 1'b0;

    frame_change_detector_fnv1a u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic void push_item(t_func func, logic [BYTE_W-1:0] data_byte,
                                      logic frame_end);
        t_bus_item item;
        item.func      = func;
        item.data_byte = data_byte;
        item.frame_end = frame_end;
        stim_q.push_back(item);
    endfunction

    task automatic queue_directed();
        push_item(FUNC_DATA, 8'h00, 1'b1);
        push_item(FUNC_DATA, 8'h00, 1'b1);
        push_item(FUNC_DATA, 8'hff, 1'b1);
        push_item(FUNC_DATA, 8'hff, 1'b0);
        push_item(FUNC_DATA, 8'h00, 1'b0);
        push_item(FUNC_DATA, 8'hff, 1'b1);
        push_item(FUNC_DATA, 8'hff, 1'b1);
        push_item(FUNC_INVALIDATE, 8'hff, 1'b1);
        push_item(FUNC_DATA, 8'hff, 1'b1);
        push_item(FUNC_DATA, 8'hff, 1'b1);
        push_item(FUNC_DATA, 8'h12, 1'b0);
        push_item(FUNC_DATA, 8'h34, 1'b0);
        push_item(FUNC_INVALIDATE, 8'h00, 1'b0);
        push_item(FUNC_DATA, 8'h56, 1'b1);
        push_item(FUNC_INVALIDATE, 8'h5a, 1'b0);
        push_item(FUNC_INVALIDATE, 8'ha5, 1'b1);
        push_item(FUNC_DATA, 8'hff, 1'b1);
        push_item(FUNC_DATA, 8'hff, 1'b1);
    endtask

    task automatic queue_random_traffic(input int n_items);
        int                made;
        int                pick;
        int                len;
        logic [BYTE_W-1:0] frame[$];
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                push_item(FUNC_INVALIDATE, BYTE_W'($urandom), 1'($urandom_range(1)));
                made++;
            end else begin
                frame.delete();
                if (pick < 50 && prev_frame.size() != 0) begin
                    frame = prev_frame;
                end else if (pick < 70 && prev_frame.size() != 0) begin
                    frame = prev_frame;
                    frame[$urandom_range(frame.size() - 1)] = BYTE_W'($urandom);
                end else begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(64, 1)
                                                   : $urandom_range(6, 1);
                    repeat (len) frame.push_back(BYTE_W'($urandom));
                end
                foreach (frame[i]) begin
                    if ($urandom_range(99) < 2)
                        push_item(FUNC_INVALIDATE, BYTE_W'($urandom),
                                  1'($urandom_range(1)));
                    push_item(FUNC_DATA, frame[i], i == frame.size() - 1);
                end
                prev_frame = frame;
                made += frame.size();
            end
        end
    endtask

    task automatic drain_stimulus();
        while (stim_q.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                board.take_item(t_func'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_item        = stim_q.pop_front();
                    s_axis_tuser  <= tx_item.func;
                    s_axis_tdata  <= tx_item.data_byte;
                    s_axis_tlast  <= tx_item.frame_end;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                board.match_verdict(m_axis_tuser, m_axis_tdata);
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // hold the receiver off so the block fills and stalls its input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #1000000;
        $display("** frame_change_detector_fnv1a: FAILED **");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 19;
        rx_idle_pct = 79;
        queue_directed();
        queue_random_traffic(560);
        drain_stimulus();

        tx_idle_pct = 79;
        rx_idle_pct = 19;
        queue_random_traffic(560);
        drain_stimulus();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pressure_go = 1'b1;
        queue_random_traffic(560);
        drain_stimulus();

        while (board.awaited_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (board.errors == 0)
            $display("** frame_change_detector_fnv1a: PASSED **");
        else
            $display("** frame_change_detector_fnv1a: FAILED **");
        $finish;
    end

endmodule
